[hw/rtl/fr_pkg.sv]
// Shared constants and pipeline stage types for the Fresnel reflectance unit.
package fr_pkg;

	localparam int VEC_FRAC_BITS = 14;
	localparam int OUT_FRAC_BITS = 15;
	// cosine magnitude is carried as Q30
	localparam int C_SHL = 30 - 2 * VEC_FRAC_BITS;
	localparam int DROP = 62 - OUT_FRAC_BITS;
	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 32;

	localparam logic [15:0] IDX_ONE = 16'd4096;
	localparam logic signed [33:0] DOT_ONE = 34'sd1 <<< (2 * VEC_FRAC_BITS);
	localparam logic [16:0] UNIT = 17'd1 << OUT_FRAC_BITS;
	localparam logic [61:0] ONE_Q60 = 62'd1 << 60;
	localparam logic [63:0] ROUND_HALF = 64'd1 << (DROP - 1);
	localparam logic [31:0] RATIO_ONE = 32'd1 << 31;

	typedef struct packed {
		logic [63:0] rad;
		logic [31:0] root;
		logic [33:0] rem;
		logic [30:0] p;
		logic [30:0] a;
		logic [15:0] ei;
		logic        tir;
	} sq_stage_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [32:0] den;
		logic [31:0] quo;
		logic        zero;
	} div_lane_t;

	typedef struct packed {
		div_lane_t s;
		div_lane_t p;
		logic      tir;
	} div_stage_t;

endpackage

[hw/rtl/fr_item_if.sv]
// Handshake channel interface for one incident/normal/index word.
interface fr_item_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] incident_x;
	logic signed [15:0] incident_y;
	logic signed [15:0] incident_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [15:0]        refr_index;

	modport source (output valid, incident_x, incident_y, incident_z,
		normal_x, normal_y, normal_z, refr_index, input ready);
	modport sink (input valid, incident_x, incident_y, incident_z,
		normal_x, normal_y, normal_z, refr_index, output ready);
endinterface

[hw/rtl/fr_result_if.sv]
// Handshake channel interface for one reflectance result word.
interface fr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] reflectance;
	logic        total_internal;

	modport source (output valid, reflectance, total_internal, input ready);
	modport sink (input valid, reflectance, total_internal, output ready);
endinterface

[hw/rtl/fresnel_reflectance.sv]
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Throughput: one word per cycle while the output register is empty or taken; a 32-step square root and two 32-step
// dividers are unrolled into register stages, one bit per stage.
// The whole pipe advances when the output register is empty or taken.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
module fresnel_reflectance
	import fr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fr_item_if.sink     item,
	fr_result_if.source result
);

	function automatic sq_stage_t sq_step(input sq_stage_t x);
		logic [35:0] rn;
		logic [35:0] trial;
		sq_stage_t   y;
		y = x;
		rn = {x.rem, x.rad[63:62]};
		trial = {2'b00, x.root, 2'b01};
		y.rad = {x.rad[61:0], 2'b00};
		if (rn >= trial) begin
			y.rem = 34'(rn - trial);
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem = rn[33:0];
			y.root = {x.root[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic div_lane_t div_step(input div_lane_t x);
		logic [33:0] sub;
		logic        ge;
		div_lane_t   y;
		y = x;
		ge = (x.rem >= {1'b0, x.den});
		sub = ge ? (x.rem - {1'b0, x.den}) : x.rem;
		y.quo = {x.quo[30:0], ge};
		y.rem = {sub[32:0], 1'b0};
		return y;
	endfunction

	function automatic div_lane_t div_init(input logic [31:0] n, input logic [31:0] d);
		div_lane_t y;
		y.den = 33'(n) + 33'(d);
		y.rem = (n >= d) ? 34'(n - d) : 34'(d - n);
		y.quo = '0;
		y.zero = (y.den == '0);
		return y;
	endfunction

	logic en;
	assign en = !result.valid || result.ready;
	assign item.ready = en;

	// S1: component products
	logic               v_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [15:0]        idx_s1;

	// S2: clamped cosine, index roles
	logic        v_s2;
	logic [30:0] c_s2;
	logic [15:0] ei_s2, et_s2;

	// S3: squares
	logic        v_s3;
	logic [60:0] cc_s3;
	logic [31:0] eie_s3, ete_s3;
	logic [30:0] c_s3;
	logic [15:0] ei_s3;

	// S4: sine squared
	logic        v_s4;
	logic [30:0] s2_s4, c_s4;
	logic [31:0] eie_s4, ete_s4;
	logic [15:0] ei_s4;

	// S5: wide products
	logic        v_s5;
	logic [62:0] m_s5, pe_s5;
	logic [46:0] ac_s5;
	logic [31:0] ete_s5;
	logic [15:0] ei_s5;

	logic      sq_v_s [SQ_STEPS+1];
	sq_stage_t sq_s   [SQ_STEPS+1];

	// S7: q and b amplitude terms
	logic        v_s7, tir_s7;
	logic [30:0] p_s7, a_s7, q_s7, b_s7;

	logic       div_v_s [DIV_STEPS+1];
	div_stage_t div_s   [DIV_STEPS+1];

	// S9, S10: energy sum
	logic        v_s9, tir_s9, v_s10, tir_s10;
	logic [63:0] rs2_s9, rp2_s9, sum_s10;

	logic        res_v_q, tir_q;
	logic [15:0] refl_q;

	logic signed [33:0] dot;
	logic signed [33:0] dot_c;
	logic [28:0]        mag;
	logic [61:0]        ets;
	logic [31:0]        rs, rp;
	logic [47:0]        eit;
	logic [64:0]        sum_w;
	logic [63:0]        rnd;
	logic [16:0]        rq;

	assign dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
	always_comb begin
		if (dot > DOT_ONE)
			dot_c = DOT_ONE;
		else if (dot < -DOT_ONE)
			dot_c = -DOT_ONE;
		else
			dot_c = dot;
		mag = dot_c[33] ? 29'(-dot_c) : 29'(dot_c);
	end

	assign ets = {ete_s5, 30'd0};
	assign eit = 48'(sq_s[SQ_STEPS].ei) * 48'(sq_s[SQ_STEPS].root);
	assign rs = div_s[DIV_STEPS].s.zero ? RATIO_ONE : div_s[DIV_STEPS].s.quo;
	assign rp = div_s[DIV_STEPS].p.zero ? RATIO_ONE : div_s[DIV_STEPS].p.quo;
	assign sum_w = 65'(rs2_s9) + 65'(rp2_s9);
	assign rnd = sum_s10 + ROUND_HALF;
	assign rq = 17'(rnd >> DROP);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sq_v_s[0] <= 1'b0;
			v_s7 <= 1'b0;
			div_v_s[0] <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			res_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sq_v_s[0] <= v_s5;
			v_s7 <= sq_v_s[SQ_STEPS];
			div_v_s[0] <= v_s7;
			v_s9 <= div_v_s[DIV_STEPS];
			v_s10 <= v_s9;
			res_v_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= item.incident_x * item.normal_x;
			py_s1 <= item.incident_y * item.normal_y;
			pz_s1 <= item.incident_z * item.normal_z;
			idx_s1 <= (item.refr_index == '0) ? 16'd1 : item.refr_index;

			c_s2 <= 31'(mag) << C_SHL;
			// ray inside the object: indices swap
			if (dot_c > 0) begin
				ei_s2 <= idx_s1;
				et_s2 <= IDX_ONE;
			end else begin
				ei_s2 <= IDX_ONE;
				et_s2 <= idx_s1;
			end

			cc_s3 <= 61'(62'(c_s2) * 62'(c_s2));
			eie_s3 <= 32'(ei_s2) * 32'(ei_s2);
			ete_s3 <= 32'(et_s2) * 32'(et_s2);
			c_s3 <= c_s2;
			ei_s3 <= ei_s2;

			s2_s4 <= 31'((ONE_Q60 - 62'(cc_s3)) >> 30);
			c_s4 <= c_s3;
			eie_s4 <= eie_s3;
			ete_s4 <= ete_s3;
			ei_s4 <= ei_s3;

			m_s5 <= 63'(eie_s4) * 63'(s2_s4);
			pe_s5 <= 63'(ete_s4) * 63'(c_s4);
			ac_s5 <= 47'(ei_s4) * 47'(c_s4);
			ete_s5 <= ete_s4;
			ei_s5 <= ei_s4;

			sq_s[0].tir <= (m_s5 >= 63'(ets));
			sq_s[0].rad <= 64'(63'(ets) - m_s5);
			sq_s[0].root <= '0;
			sq_s[0].rem <= '0;
			sq_s[0].p <= pe_s5[62:32];
			sq_s[0].a <= ac_s5[46:16];
			sq_s[0].ei <= ei_s5;

			tir_s7 <= sq_s[SQ_STEPS].tir;
			p_s7 <= sq_s[SQ_STEPS].p;
			a_s7 <= sq_s[SQ_STEPS].a;
			q_s7 <= eit[47:17];
			b_s7 <= sq_s[SQ_STEPS].root[31:1];

			div_s[0].tir <= tir_s7;
			div_s[0].s <= div_init(32'(p_s7), 32'(q_s7));
			div_s[0].p <= div_init(32'(a_s7), 32'(b_s7));

			rs2_s9 <= 64'(rs) * 64'(rs);
			rp2_s9 <= 64'(rp) * 64'(rp);
			tir_s9 <= div_s[DIV_STEPS].tir;

			sum_s10 <= sum_w[64:1];
			tir_s10 <= tir_s9;

			tir_q <= tir_s10;
			if (tir_s10 || rq > UNIT)
				refl_q <= UNIT[15:0];
			else
				refl_q <= rq[15:0];
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k+1] <= 1'b0;
			else if (en)
				sq_v_s[k+1] <= sq_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (en)
				sq_s[k+1] <= sq_step(sq_s[k]);
		end
	end

	// s and p amplitude dividers, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v_s[k+1] <= 1'b0;
			else if (en)
				div_v_s[k+1] <= div_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1].s <= div_step(div_s[k].s);
				div_s[k+1].p <= div_step(div_s[k].p);
				div_s[k+1].tir <= div_s[k].tir;
			end
		end
	end

	assign result.valid = res_v_q;
	assign result.reflectance = refl_q;
	assign result.total_internal = tir_q;

	a_tir_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.total_internal |-> result.reflectance == UNIT[15:0])
		else $error("total internal reflection without unit reflectance");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.reflectance <= UNIT[15:0])
		else $error("reflectance above one");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en && !v_s10 |=> !result.valid)
		else $error("result word without a word in the last stage");

endmodule

[tb/fresnel_reflectance_tb.sv]
// Self-checking testbench for the Fresnel reflectance unit with its own bit-exact predictor.
module fresnel_reflectance_tb
	import fr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] ix, iy, iz;
		logic signed [15:0] nx, ny, nz;
		logic [15:0]        idx;
		bit                 drain_first;
	} hit_t;

	typedef struct {
		logic [15:0] refl;
		logic        tir;
	} refl_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fr_item_if   item();
	fr_result_if result();

	fresnel_reflectance u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hit_t  hit_queue[$];
	refl_t refl_expected[$];
	int    errors = 0;
	bit    hit_taken = 0;
	bit    quiet = 0;
	bit    loaded = 0;
	int    send_gap = 0;
	int    stall_gap = 0;

	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] r, bit_pos;
		r = 0;
		bit_pos = 64'd1 << 62;
		while (bit_pos > x) bit_pos = bit_pos >> 2;
		while (bit_pos != 0) begin
			if (x >= r + bit_pos) begin
				x = x - (r + bit_pos);
				r = (r >> 1) + bit_pos;
			end else begin
				r = r >> 1;
			end
			bit_pos = bit_pos >> 2;
		end
		return r;
	endfunction

	// |n-d| / (n+d) in Q31, one when both are zero
	function automatic logic [63:0] amplitude_ratio(logic [63:0] n, logic [63:0] d);
		logic [63:0] diff, sum;
		diff = (n >= d) ? n - d : d - n;
		sum = n + d;
		if (sum == 0) return 64'd1 << 31;
		return (diff << 31) / sum;
	endfunction

	function automatic refl_t predict_reflectance(hit_t h);
		longint signed dot, one;
		logic [63:0] c, s2, ei, et, tmp, d, tq, p, q, a, b, rs, rp, sum, r;
		refl_t o;
		dot = longint'(h.ix) * longint'(h.nx) + longint'(h.iy) * longint'(h.ny)
			+ longint'(h.iz) * longint'(h.nz);
		one = longint'(1) <<< (2 * VEC_FRAC_BITS);
		if (dot > one) dot = one;
		if (dot < -one) dot = -one;
		c = (dot < 0) ? 64'(-dot) : 64'(dot);
		if (C_SHL >= 0) c = c << C_SHL;
		else c = c >> (-C_SHL);
		ei = 64'(IDX_ONE);
		et = 64'(h.idx);
		if (et == 0) et = 1;
		// ray leaving the object: indices trade places
		if (dot > 0) begin
			tmp = ei; ei = et; et = tmp;
		end
		s2 = ((64'd1 << 60) - c * c) >> 30;
		if (ei * ei * s2 >= ((et * et) << 30)) begin
			o.refl = 16'(UNIT);
			o.tir = 1'b1;
			return o;
		end
		d = ((et * et) << 30) - ei * ei * s2;
		tq = isqrt64(d);
		p = (et * et * c) >> 32;
		q = (ei * tq) >> 17;
		a = (ei * c) >> 16;
		b = tq >> 1;
		rs = amplitude_ratio(p, q);
		rp = amplitude_ratio(a, b);
		sum = (rs * rs + rp * rp) >> 1;
		r = (sum + (64'd1 << (DROP - 1))) >> DROP;
		if (r > 64'(UNIT)) r = 64'(UNIT);
		o.refl = r[15:0];
		o.tir = 1'b0;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// monitor: both handshakes sampled at the rising edge
	always @(posedge clk) begin
		hit_t  h;
		refl_t w;
		hit_taken = item.valid && item.ready;
		if (hit_taken) begin
			h.ix = item.incident_x; h.iy = item.incident_y; h.iz = item.incident_z;
			h.nx = item.normal_x; h.ny = item.normal_y; h.nz = item.normal_z;
			h.idx = item.refr_index;
			h.drain_first = 0;
			refl_expected.push_back(predict_reflectance(h));
		end
		if (result.valid && result.ready) begin
			if (refl_expected.size() == 0) begin
				report_mismatch("unexpected word", result.reflectance, -1);
			end else begin
				w = refl_expected.pop_front();
				if (result.reflectance !== w.refl)
					report_mismatch("reflectance", result.reflectance, w.refl);
				if (result.total_internal !== w.tir)
					report_mismatch("total_internal", result.total_internal, w.tir);
			end
		end
	end

	// driver: inputs change at the falling edge
	always @(negedge clk) begin
		hit_t h;
		if (arst_n) begin
			if (!item.valid || hit_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					item.valid <= 1'b0;
				end else if (hit_queue.size() != 0 &&
					!(hit_queue[0].drain_first && refl_expected.size() != 0)) begin
					h = hit_queue.pop_front();
					item.incident_x <= h.ix; item.incident_y <= h.iy;
					item.incident_z <= h.iz;
					item.normal_x <= h.nx; item.normal_y <= h.ny; item.normal_z <= h.nz;
					item.refr_index <= h.idx;
					item.valid <= 1'b1;
					if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
				end else begin
					item.valid <= 1'b0;
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) stall_gap = $urandom_range(1, 5);
			end
			quiet = loaded && hit_queue.size() < 120;
		end
	end

	task automatic add_hit(int ix, int iy, int iz, int nx, int ny, int nz, int idx,
		bit drain = 0);
		hit_t h;
		h.ix = 16'(ix); h.iy = 16'(iy); h.iz = 16'(iz);
		h.nx = 16'(nx); h.ny = 16'(ny); h.nz = 16'(nz);
		h.idx = 16'(idx);
		h.drain_first = drain;
		hit_queue.push_back(h);
	endtask

	function automatic int rand_s16();
		return int'($signed(16'($urandom())));
	endfunction

	initial begin
		int k;
		int comp;
		item.valid = 1'b0;
		item.incident_x = 0; item.incident_y = 0; item.incident_z = 0;
		item.normal_x = 0; item.normal_y = 0; item.normal_z = 0;
		item.refr_index = 0;
		result.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// head-on from outside and inside, glass and water
		add_hit(0, 0, -16384, 0, 0, 16384, 6144);
		add_hit(0, 0, 16384, 0, 0, 16384, 6144);
		add_hit(0, 0, -16384, 0, 0, 16384, 5448);
		// index zero falls back to the raw value 1; also index one exactly
		add_hit(0, 0, -16384, 0, 0, 16384, 0);
		add_hit(0, 0, -16384, 0, 0, 16384, 4096);
		add_hit(0, 0, -16384, 0, 0, 16384, 1);
		add_hit(0, 0, -16384, 0, 0, 16384, 65535);
		// grazing: dot product zero, and near zero at index one
		add_hit(16384, 0, 0, 0, 0, 16384, 6144);
		add_hit(16384, 0, 0, 0, 0, 16384, 4096);
		add_hit(16384, 0, 1, 0, 0, 16384, 4096);
		add_hit(16384, 0, -1, 0, 0, 16384, 4096);
		// leaving glass at a steep angle: total internal reflection
		add_hit(15000, 0, 6000, 0, 0, 16384, 6144);
		add_hit(11585, 0, 11585, 0, 0, 16384, 6144);
		// field extremes, dot clamped both ways
		add_hit(32767, 32767, 32767, 32767, 32767, 32767, 65535);
		add_hit(-32768, -32768, -32768, 32767, 32767, 32767, 65535);
		add_hit(-32768, -32768, -32768, -32768, -32768, -32768, 1);
		add_hit(32767, -32768, 0, -32768, 32767, 0, 32768);
		add_hit(0, 0, 0, 0, 0, 0, 6144);
		add_hit(0, 0, 0, 0, 0, 0, 0, 1);
		add_hit(-11585, 0, -11585, 0, 0, 16384, 12288);
		add_hit(1, 1, 1, 1, 1, 1, 2048);

		for (k = 0; k < 850; k++) begin
			comp = $urandom_range(0, 9);
			if (comp < 6)
				// roughly unit vectors, plausible indices
				add_hit($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
					$urandom_range(0, 32768) - 16384, $urandom_range(0, 16384) - 8192,
					$urandom_range(0, 16384) - 8192, $urandom_range(8192, 16384),
					$urandom_range(2048, 12288), k == 400);
			else if (comp < 8)
				add_hit(rand_s16(), rand_s16(), rand_s16(), rand_s16(), rand_s16(),
					rand_s16(), $urandom_range(0, 65535), k == 400);
			else
				add_hit($urandom_range(0, 32768) - 16384, 0, $urandom_range(0, 200) - 100,
					0, 0, 16384, $urandom_range(3900, 4300), k == 400);
		end
		loaded = 1;

		while (hit_queue.size() != 0 || item.valid) @(posedge clk);
		while (refl_expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/fr_pkg.sv
hw/rtl/fr_item_if.sv
hw/rtl/fr_result_if.sv
hw/rtl/fresnel_reflectance.sv
tb/fresnel_reflectance_tb.sv
